// ===== rtl/core/srr_pkg.sv =====
// ============================================================================
// srr_pkg
// Shared types and constants for the square region rotator: operation codes,
// sequencer states and the fixed field widths of the stream words.
// ============================================================================
`default_nettype none

package srr_pkg;

  // Field widths of the input and result words
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CoordW  = 10;
  localparam int unsigned RadiusW = 8;
  localparam int unsigned ValW    = 19;
  localparam int unsigned SizeW   = 10;
  // Side in use, wide enough to hold the largest grid parameter
  localparam int unsigned SideW   = 11;
  // Signed coordinate arithmetic for ring addresses
  localparam int unsigned SCoordW = 12;
  // Signed offset along one ring edge
  localparam int unsigned OffW    = RadiusW + 1;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;

  localparam logic [SizeW-1:0] GridSizeReset = 10'd512;

  // Operation codes carried in the input tuser
  typedef enum logic [ModeW-1:0] {
    OP_FILL   = 2'd0,
    OP_ROTATE = 2'd1,
    OP_READ   = 2'd2,
    OP_WRITE  = 2'd3
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_ROT_RD,
    ST_ROT_WR,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  // Ring corner taken in one step of a rotation
  typedef enum logic [1:0] {
    SIDE_TOP = 2'd0,
    SIDE_RGT = 2'd1,
    SIDE_BOT = 2'd2,
    SIDE_LFT = 2'd3
  } corner_t;

endpackage

`default_nettype wire

// ===== rtl/core/square_region_rotator_top.sv =====
// ============================================================================
// square_region_rotator_top
// Square grid of cells held in one synchronous memory; fills it with running
// numbers, rotates square regions by a quarter turn in place, reads and
// writes single cells.
// ============================================================================
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  in_      | slave     | tuser: mode; tdata: row, col, radius, ccw, write value
//  out_     | master    | tuser: out_of_range; tdata: read_value
//  cfg_     | slave     | data: grid_size
//
//  The single memory port pair gives one read and one write a cycle; a
//  rotation moves its cells in groups of four. Reset is synchronous, active
//  low; grid_size returns to 512 and the grid contents stay undefined. A
//  stalled result waits in the output register; a new word is taken as soon
//  as the sequencer is idle.
// ============================================================================
`default_nettype none

module square_region_rotator_top #(
  parameter int unsigned MAX_SIZE = 512
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [srr_pkg::SizeW-1:0]       cfg_data,     // grid_size
  // input words
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [9:0] row, [19:10] col, [27:20] radius, [28] counterclockwise,
  // [47:29] write_value
  input  wire logic [srr_pkg::InDataW-1:0]     in_tdata,
  input  wire logic [srr_pkg::ModeW-1:0]       in_tuser,     // [1:0] mode
  // result words
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [srr_pkg::OutDataW-1:0]         out_tdata,    // [18:0] read_value
  output logic                                 out_tuser     // [0] out_of_range
);

  localparam int unsigned IdxW  = $clog2(MAX_SIZE);
  localparam int unsigned AddrW = 2 * IdxW;
  localparam int unsigned Depth = 1 << AddrW;
  localparam logic [srr_pkg::SideW-1:0] MaxSide = srr_pkg::SideW'(MAX_SIZE);

  // --------------------------------------------------------------------------
  // Input word fields
  // --------------------------------------------------------------------------
  srr_pkg::op_t                   in_op;
  logic [srr_pkg::CoordW-1:0]     in_row;
  logic [srr_pkg::CoordW-1:0]     in_col;
  logic [srr_pkg::RadiusW-1:0]    in_rad;
  logic                           in_ccw;
  logic [srr_pkg::ValW-1:0]       in_wval;

  assign in_op   = srr_pkg::op_t'(in_tuser);
  assign in_row  = in_tdata[9:0];
  assign in_col  = in_tdata[19:10];
  assign in_rad  = in_tdata[27:20];
  assign in_ccw  = in_tdata[28];
  assign in_wval = in_tdata[47:29];

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  srr_pkg::state_t                state_r, state_nxt;
  logic [srr_pkg::SizeW-1:0]      grid_size_r;
  logic [srr_pkg::CoordW-1:0]     ctr_row_r, ctr_row_nxt;
  logic [srr_pkg::CoordW-1:0]     ctr_col_r, ctr_col_nxt;
  logic [srr_pkg::RadiusW-1:0]    ring_r, ring_nxt;
  logic signed [srr_pkg::OffW-1:0] off_r, off_nxt;
  logic                           ccw_r, ccw_nxt;
  logic [1:0]                     k_r, k_nxt;
  logic [srr_pkg::ValW-1:0]       v_r [4];
  logic                           rd_pend_r;
  logic [1:0]                     rd_k_r;
  logic [IdxW-1:0]                fr_r, fr_nxt;
  logic [IdxW-1:0]                fc_r, fc_nxt;
  logic [srr_pkg::ValW-1:0]       num_r, num_nxt;
  logic [srr_pkg::ValW-1:0]       res_val_r, res_val_nxt;
  logic                           res_oor_r, res_oor_nxt;
  logic                           out_valid_r;
  logic [srr_pkg::ValW-1:0]       out_val_r;
  logic                           out_oor_r;

  // --------------------------------------------------------------------------
  // Grid memory
  // --------------------------------------------------------------------------
  logic [srr_pkg::ValW-1:0]       mem_q [Depth];
  logic                           mem_we;
  logic [AddrW-1:0]               mem_waddr;
  logic [AddrW-1:0]               mem_raddr;
  logic [srr_pkg::ValW-1:0]       mem_wdata;
  logic [srr_pkg::ValW-1:0]       mem_rdata_r;

  // Write one cell and read one cell a cycle; read data is registered and lands in the next cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem_q[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // Side in use and range checks
  // --------------------------------------------------------------------------
  logic [srr_pkg::SideW-1:0] side;
  logic [srr_pkg::SideW-1:0] side_m1;
  logic [srr_pkg::SideW-1:0] row_e, col_e, rad_e;
  logic                      cell_oor;
  logic                      region_oor;

  assign side    = (srr_pkg::SideW'(grid_size_r) > MaxSide) ? MaxSide
                                                             : srr_pkg::SideW'(grid_size_r);
  assign side_m1 = side - srr_pkg::SideW'(1);
  assign row_e   = srr_pkg::SideW'(in_row);
  assign col_e   = srr_pkg::SideW'(in_col);
  assign rad_e   = srr_pkg::SideW'(in_rad);

  assign cell_oor   = (row_e == '0) || (col_e == '0) || (row_e > side) || (col_e > side);
  assign region_oor = (row_e <= rad_e) || (col_e <= rad_e) ||
                      (row_e + rad_e > side) || (col_e + rad_e > side);

  // --------------------------------------------------------------------------
  // Ring corner address for the current step
  // --------------------------------------------------------------------------
  logic signed [srr_pkg::SCoordW-1:0] sx, sy, si, sj;
  logic signed [srr_pkg::SCoordW-1:0] cr, cc;
  logic [AddrW-1:0]                   rot_addr;

  assign sx = $signed(srr_pkg::SCoordW'(ctr_row_r));
  assign sy = $signed(srr_pkg::SCoordW'(ctr_col_r));
  assign si = $signed(srr_pkg::SCoordW'(ring_r));
  assign sj = srr_pkg::SCoordW'(off_r);

  always_comb begin
    unique case (srr_pkg::corner_t'(k_r))
      srr_pkg::SIDE_TOP: begin cr = sx - si; cc = sy + sj; end
      srr_pkg::SIDE_RGT: begin cr = sx + sj; cc = sy + si; end
      srr_pkg::SIDE_BOT: begin cr = sx + si; cc = sy - sj; end
      srr_pkg::SIDE_LFT: begin cr = sx - sj; cc = sy - si; end
      default:           begin cr = sx;      cc = sy;      end
    endcase
  end

  assign rot_addr = {cr[IdxW-1:0], cc[IdxW-1:0]};

  // Value moved into the corner being written, forwarding the last read
  logic [1:0]                src_k;
  logic [srr_pkg::ValW-1:0]  rot_wdata;

  assign src_k     = ccw_r ? (k_r + 2'd1) : (k_r - 2'd1);
  assign rot_wdata = (rd_pend_r && (rd_k_r == src_k)) ? mem_rdata_r : v_r[src_k];

  // --------------------------------------------------------------------------
  // Step conditions
  // --------------------------------------------------------------------------
  logic in_acc;
  logic out_free;
  logic fill_last_col;
  logic fill_last;
  logic ring_end;
  logic ring_last;

  assign in_acc        = in_tvalid && in_tready;
  assign out_free      = !out_valid_r || out_tready;
  assign fill_last_col = (srr_pkg::SideW'(fc_r) == side_m1);
  assign fill_last     = fill_last_col && (srr_pkg::SideW'(fr_r) == side_m1);
  assign ring_end      = (off_r == ($signed({1'b0, ring_r}) - srr_pkg::OffW'(1)));
  assign ring_last     = (ring_r == srr_pkg::RadiusW'(1));

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srr_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            srr_pkg::OP_FILL:   state_nxt = (side == '0) ? srr_pkg::ST_DONE
                                                         : srr_pkg::ST_FILL;
            srr_pkg::OP_ROTATE: state_nxt = (region_oor || (in_rad == '0))
                                            ? srr_pkg::ST_DONE : srr_pkg::ST_ROT_RD;
            srr_pkg::OP_READ:   state_nxt = cell_oor ? srr_pkg::ST_DONE
                                                     : srr_pkg::ST_READ_WAIT;
            srr_pkg::OP_WRITE:  state_nxt = srr_pkg::ST_DONE;
            default:            state_nxt = srr_pkg::ST_DONE;
          endcase
        end
      end
      srr_pkg::ST_FILL: begin
        if (fill_last) begin
          state_nxt = srr_pkg::ST_DONE;
        end
      end
      srr_pkg::ST_ROT_RD: begin
        if (k_r == 2'd3) begin
          state_nxt = srr_pkg::ST_ROT_WR;
        end
      end
      srr_pkg::ST_ROT_WR: begin
        if (k_r == 2'd3) begin
          state_nxt = (ring_end && ring_last) ? srr_pkg::ST_DONE : srr_pkg::ST_ROT_RD;
        end
      end
      srr_pkg::ST_READ_WAIT: state_nxt = srr_pkg::ST_DONE;
      srr_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = srr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srr_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and memory control
  // --------------------------------------------------------------------------
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = rot_addr;
    mem_wdata   = rot_wdata;
    mem_raddr   = rot_addr;
    ctr_row_nxt = ctr_row_r;
    ctr_col_nxt = ctr_col_r;
    ring_nxt    = ring_r;
    off_nxt     = off_r;
    ccw_nxt     = ccw_r;
    k_nxt       = k_r;
    fr_nxt      = fr_r;
    fc_nxt      = fc_r;
    num_nxt     = num_r;
    res_val_nxt = res_val_r;
    res_oor_nxt = res_oor_r;
    unique case (state_r)
      srr_pkg::ST_IDLE: begin
        // Read and write go straight to the memory from the input word
        mem_raddr = {IdxW'(in_row - srr_pkg::CoordW'(1)),
                     IdxW'(in_col - srr_pkg::CoordW'(1))};
        mem_waddr = mem_raddr;
        mem_wdata = in_wval;
        if (in_acc) begin
          res_val_nxt = '0;
          res_oor_nxt = 1'b0;
          ctr_row_nxt = in_row - srr_pkg::CoordW'(1);
          ctr_col_nxt = in_col - srr_pkg::CoordW'(1);
          ring_nxt    = in_rad;
          off_nxt     = -$signed({1'b0, in_rad});
          ccw_nxt     = in_ccw;
          k_nxt       = 2'd0;
          fr_nxt      = '0;
          fc_nxt      = '0;
          num_nxt     = srr_pkg::ValW'(1);
          unique case (in_op)
            srr_pkg::OP_FILL:   ;
            srr_pkg::OP_ROTATE: res_oor_nxt = region_oor;
            srr_pkg::OP_READ:   res_oor_nxt = cell_oor;
            srr_pkg::OP_WRITE: begin
              res_oor_nxt = cell_oor;
              mem_we      = !cell_oor;
            end
            default: ;
          endcase
        end
      end
      srr_pkg::ST_FILL: begin
        // Number one cell a cycle, row by row
        mem_we    = 1'b1;
        mem_waddr = {fr_r, fc_r};
        mem_wdata = num_r;
        num_nxt   = num_r + srr_pkg::ValW'(1);
        if (fill_last_col) begin
          fc_nxt = '0;
          fr_nxt = fr_r + IdxW'(1);
        end else begin
          fc_nxt = fc_r + IdxW'(1);
        end
      end
      srr_pkg::ST_ROT_RD: begin
        // Fetch the four corners of the current ring step
        k_nxt = k_r + 2'd1;
      end
      srr_pkg::ST_ROT_WR: begin
        // Write each corner with its neighbour's value, then advance
        mem_we = 1'b1;
        k_nxt  = k_r + 2'd1;
        if (k_r == 2'd3) begin
          if (ring_end) begin
            ring_nxt = ring_r - srr_pkg::RadiusW'(1);
            off_nxt  = srr_pkg::OffW'(1) - $signed({1'b0, ring_r});
          end else begin
            off_nxt = off_r + srr_pkg::OffW'(1);
          end
        end
      end
      srr_pkg::ST_READ_WAIT: res_val_nxt = mem_rdata_r;
      srr_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srr_pkg::ST_IDLE;
      grid_size_r <= srr_pkg::GridSizeReset;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == srr_pkg::ST_ROT_RD);
      if (cfg_valid && cfg_ready) begin
        grid_size_r <= cfg_data;
      end
      // Hold the result until the sink takes it
      if ((state_r == srr_pkg::ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    ctr_row_r <= ctr_row_nxt;
    ctr_col_r <= ctr_col_nxt;
    ring_r    <= ring_nxt;
    off_r     <= off_nxt;
    ccw_r     <= ccw_nxt;
    k_r       <= k_nxt;
    fr_r      <= fr_nxt;
    fc_r      <= fc_nxt;
    num_r     <= num_nxt;
    res_val_r <= res_val_nxt;
    res_oor_r <= res_oor_nxt;
    rd_k_r    <= k_r;
    // Park the corner fetched in the previous cycle
    if (rd_pend_r) begin
      v_r[rd_k_r] <= mem_rdata_r;
    end
    if ((state_r == srr_pkg::ST_DONE) && out_free) begin
      out_val_r <= res_val_r;
      out_oor_r <= res_oor_r;
    end
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == srr_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = srr_pkg::OutDataW'(out_val_r);
  assign out_tuser  = out_oor_r;

endmodule

`default_nettype wire

// ===== tb/sv/srr_grid_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// srr_grid_checker
// Passive checker for the square region rotator. Keeps its own copy of the
// grid and of grid_size, works out the result of every accepted input word
// and compares each result word against the oldest outstanding prediction.
// ============================================================================

module srr_grid_checker #(
  parameter int unsigned MAX_SIZE = 512
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [srr_pkg::SizeW-1:0]       cfg_data,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  input  wire logic [srr_pkg::InDataW-1:0]     in_tdata,
  input  wire logic [srr_pkg::ModeW-1:0]       in_tuser,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [srr_pkg::OutDataW-1:0]    out_tdata,
  input  wire logic                            out_tuser,
  output int                                   error_count,
  output int                                   pending
);

  // Bit positions inside the input tdata
  localparam int unsigned ColLsb    = srr_pkg::CoordW;
  localparam int unsigned RadLsb    = 2 * srr_pkg::CoordW;
  localparam int unsigned CcwBit    = 2 * srr_pkg::CoordW + srr_pkg::RadiusW;
  localparam int unsigned WvalLsb   = CcwBit + 1;
  localparam int unsigned CellCount = MAX_SIZE * MAX_SIZE;

  typedef struct packed {
    logic [srr_pkg::ValW-1:0] read_value;
    logic                     out_of_range;
  } grid_result_t;

  logic [srr_pkg::ValW-1:0]  grid_cells [CellCount];
  logic [srr_pkg::SizeW-1:0] grid_size;
  grid_result_t              due_results [$];
  int                        fails = 0;

  function automatic int unsigned cell_at(int r, int c);
    return (r - 1) * MAX_SIZE + (c - 1);
  endfunction

  // Turn the square around (x, y) a quarter turn, outermost ring first
  task automatic turn_region(input int x, input int y, input int rad, input bit ccw);
    int unsigned t_i, r_i, b_i, l_i;
    logic [srr_pkg::ValW-1:0] held;
    for (int i = rad; i >= 1; i--) begin
      for (int j = -i; j < i; j++) begin
        t_i  = cell_at(x - i, y + j);
        r_i  = cell_at(x + j, y + i);
        b_i  = cell_at(x + i, y - j);
        l_i  = cell_at(x - j, y - i);
        held = grid_cells[t_i];
        if (!ccw) begin
          grid_cells[t_i] = grid_cells[l_i];
          grid_cells[l_i] = grid_cells[b_i];
          grid_cells[b_i] = grid_cells[r_i];
          grid_cells[r_i] = held;
        end else begin
          grid_cells[t_i] = grid_cells[r_i];
          grid_cells[r_i] = grid_cells[b_i];
          grid_cells[b_i] = grid_cells[l_i];
          grid_cells[l_i] = held;
        end
      end
    end
  endtask

  // Apply one input word to the grid copy and work out its result word
  task automatic apply_grid_op(input srr_pkg::op_t op, input int row, input int col,
                               input int rad, input bit ccw,
                               input logic [srr_pkg::ValW-1:0] wval,
                               output grid_result_t res);
    int n;
    int unsigned num;
    n   = (grid_size > MAX_SIZE) ? MAX_SIZE : grid_size;
    res = '0;
    case (op)
      srr_pkg::OP_FILL: begin
        num = 0;
        for (int i = 1; i <= n; i++) begin
          for (int j = 1; j <= n; j++) begin
            num++;
            grid_cells[cell_at(i, j)] = num[srr_pkg::ValW-1:0];
          end
        end
      end
      srr_pkg::OP_ROTATE: begin
        if (row - rad < 1 || col - rad < 1 || row + rad > n || col + rad > n)
          res.out_of_range = 1'b1;
        else
          turn_region(row, col, rad, ccw);
      end
      default: begin
        if (row < 1 || col < 1 || row > n || col > n)
          res.out_of_range = 1'b1;
        else if (op == srr_pkg::OP_READ)
          res.read_value = grid_cells[cell_at(row, col)];
        else
          grid_cells[cell_at(row, col)] = wval;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what,
                                 input logic [srr_pkg::ValW-1:0] want_v,
                                 input logic [srr_pkg::ValW-1:0] got_v);
    fails++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
  endtask

  // Compare result words first, then take config and input words
  always @(posedge clk) begin
    grid_result_t seen, want, res;
    if (!rst_n) begin
      grid_size = srr_pkg::GridSizeReset;
      due_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen.read_value   = out_tdata[srr_pkg::ValW-1:0];
        seen.out_of_range = out_tuser;
        if (due_results.size() == 0) begin
          fails++;
          $display("%0t: result word with none outstanding, expected nothing, %s %0h/%0b",
                   $time, "actual", seen.read_value, seen.out_of_range);
        end else begin
          want = due_results.pop_front();
          if (seen.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, seen.read_value);
          if (seen.out_of_range !== want.out_of_range)
            report_mismatch("out_of_range", want.out_of_range, seen.out_of_range);
        end
      end
      if (cfg_valid && cfg_ready)
        grid_size = cfg_data;
      if (in_tvalid && in_tready) begin
        apply_grid_op(srr_pkg::op_t'(in_tuser),
                      int'(in_tdata[srr_pkg::CoordW-1:0]),
                      int'(in_tdata[ColLsb +: srr_pkg::CoordW]),
                      int'(in_tdata[RadLsb +: srr_pkg::RadiusW]),
                      in_tdata[CcwBit],
                      in_tdata[WvalLsb +: srr_pkg::ValW],
                      res);
        due_results.push_back(res);
      end
    end
    pending     <= due_results.size();
    error_count <= fails;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Stimulus and verdict for the square region rotator. Numbers the full grid
// once, runs a short directed set over field extremes and grid sizes, then
// random words under four sender/receiver idling mixes, with long result
// hold-offs and drained pauses; the checker beside the block does the scoring.
// ============================================================================

module tb_top;

  localparam int unsigned MaxSize       = 512;
  localparam int          LimitCycles   = 2_000_000;
  localparam int          HoldCycles    = 300;
  localparam int          TailCycles    = 64;
  localparam int          WordsPerPhase = 19;
  localparam int          MaxTurnRadius = 6;
  localparam int unsigned CheapFillSide = 32;

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         cfg_valid  = 1'b0;
  logic                         cfg_ready;
  logic [srr_pkg::SizeW-1:0]    cfg_data   = '0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [srr_pkg::InDataW-1:0]  in_tdata   = '0;
  logic [srr_pkg::ModeW-1:0]    in_tuser   = '0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [srr_pkg::OutDataW-1:0] out_tdata;
  logic                         out_tuser;

  int error_count;
  int pending;

  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          hold_ticket  = 0;
  int          hold_served  = 0;
  int          hold_left    = 0;
  int          cycles       = 0;
  int unsigned grid_n       = MaxSize;
  int          sizes_used   = 1;
  int          op_count [4] = '{default: 0};

  square_region_rotator_top #(.MAX_SIZE(MaxSize)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  srr_grid_checker #(.MAX_SIZE(MaxSize)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .error_count (error_count),
    .pending     (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("%0t: cycle limit reached with %0d results outstanding", $time, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_served != hold_ticket) begin
      hold_served <= hold_ticket;
      hold_left   <= HoldCycles;
      out_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offer one input word, with a random gap first; valid stays high after
  task automatic send_word(input srr_pkg::op_t op, input int row, input int col,
                           input int rad, input bit ccw,
                           input logic [srr_pkg::ValW-1:0] wval);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {wval, ccw, srr_pkg::RadiusW'(rad), srr_pkg::CoordW'(col),
                  srr_pkg::CoordW'(row)};
    do @(posedge clk); while (!in_tready);
    op_count[op]++;
  endtask

  // Drop valid and hold until every result word has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write grid_size while the block is idle
  task automatic set_grid(input int unsigned size);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= srr_pkg::SizeW'(size);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    grid_n     = (size > MaxSize) ? MaxSize : size;
    sizes_used++;
  endtask

  // Mostly in-range words with random content, some noise
  task automatic random_word();
    int pick, lim, rad, row, col;
    srr_pkg::op_t op;
    pick = $urandom_range(99);
    lim  = (grid_n == 0) ? 0 : (grid_n - 1) / 2;
    if (lim > MaxTurnRadius)
      lim = MaxTurnRadius;
    if (pick < 8 && grid_n <= CheapFillSide) begin
      send_word(srr_pkg::OP_FILL, $urandom_range(1023), $urandom_range(1023),
                $urandom_range(255), 1'($urandom_range(1)), srr_pkg::ValW'($urandom));
    end else if (pick < 38 && grid_n != 0) begin
      rad = $urandom_range(lim);
      send_word(srr_pkg::OP_ROTATE, $urandom_range(grid_n - rad, rad + 1),
                $urandom_range(grid_n - rad, rad + 1), rad, 1'($urandom_range(1)),
                srr_pkg::ValW'($urandom));
    end else if (pick < 62 && grid_n != 0) begin
      send_word(srr_pkg::OP_READ, $urandom_range(grid_n, 1), $urandom_range(grid_n, 1),
                $urandom_range(255), 1'($urandom_range(1)), srr_pkg::ValW'($urandom));
    end else if (pick < 86 && grid_n != 0) begin
      send_word(srr_pkg::OP_WRITE, $urandom_range(grid_n, 1), $urandom_range(grid_n, 1),
                $urandom_range(255), 1'($urandom_range(1)), srr_pkg::ValW'($urandom));
    end else begin
      // noise: any field value, but keep a big accepted rotation or fill out of reach
      op  = srr_pkg::op_t'($urandom_range(3));
      row = $urandom_range(1023);
      col = $urandom_range(1023);
      rad = $urandom_range(255);
      if (op == srr_pkg::OP_FILL && grid_n > CheapFillSide)
        op = srr_pkg::OP_READ;
      if (op == srr_pkg::OP_ROTATE && rad > MaxTurnRadius)
        row = rad;
      send_word(op, row, col, rad, 1'($urandom_range(1)), srr_pkg::ValW'($urandom));
    end
  endtask

  initial begin
    int tx_mix [4];
    int rx_mix [4];
    int unsigned side_mix [4];
    tx_mix   = '{0, 85, 0, 34};
    rx_mix   = '{0, 0, 85, 34};
    side_mix = '{5, 8, 1023, $urandom_range(20, 2)};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: number the whole grid at the reset size, then corners and limits
    send_word(srr_pkg::OP_FILL,   0,    0,    0,   1'b0, '0);
    send_word(srr_pkg::OP_READ,   1,    1,    0,   1'b0, '0);
    send_word(srr_pkg::OP_READ,   512,  512,  0,   1'b0, '0);
    send_word(srr_pkg::OP_WRITE,  512,  512,  0,   1'b0, '1);
    send_word(srr_pkg::OP_READ,   512,  512,  255, 1'b1, '0);
    send_word(srr_pkg::OP_READ,   0,    5,    0,   1'b0, '0);
    send_word(srr_pkg::OP_WRITE,  513,  1023, 0,   1'b0, '1);
    send_word(srr_pkg::OP_ROTATE, 255,  255,  255, 1'b0, '0);
    send_word(srr_pkg::OP_ROTATE, 1023, 1023, 0,   1'b1, '0);
    send_word(srr_pkg::OP_ROTATE, 510,  510,  2,   1'b0, '0);
    send_word(srr_pkg::OP_READ,   508,  508,  0,   1'b0, '0);
    send_word(srr_pkg::OP_ROTATE, 4,    4,    3,   1'b1, '0);
    send_word(srr_pkg::OP_ROTATE, 512,  512,  0,   1'b1, '0);
    // Smallest grid: one cell
    set_grid(1);
    send_word(srr_pkg::OP_FILL,   0,    0,    0,   1'b0, '0);
    send_word(srr_pkg::OP_READ,   1,    1,    0,   1'b0, '0);
    send_word(srr_pkg::OP_READ,   1,    2,    0,   1'b0, '0);
    send_word(srr_pkg::OP_ROTATE, 1,    1,    0,   1'b0, '0);
    // Empty grid: everything refused, fill does nothing
    set_grid(0);
    send_word(srr_pkg::OP_FILL,   0,    0,    0,   1'b0, '0);
    send_word(srr_pkg::OP_READ,   1,    1,    0,   1'b0, '0);
    send_word(srr_pkg::OP_ROTATE, 1,    1,    0,   1'b1, '0);
    // Size above the parameter clamps to it
    set_grid(1023);
    send_word(srr_pkg::OP_READ,   512,  512,  0,   1'b0, '0);
    send_word(srr_pkg::OP_READ,   513,  1,    0,   1'b0, '0);
    send_word(srr_pkg::OP_ROTATE, 511,  511,  1,   1'b1, '0);
    send_word(srr_pkg::OP_READ,   512,  510,  0,   1'b0, '0);

    // Random phases, one idling mix and grid size each
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  <= tx_mix[p];
      rx_stall_pct <= rx_mix[p];
      set_grid(side_mix[p]);
      for (int k = 0; k < WordsPerPhase; k++) begin
        if ((p == 0 && k == 8) || (p == 3 && k == 5))
          hold_ticket <= hold_ticket + 1;
        if (k == 15)
          drain_results();
        random_word();
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk);
    $display("Covered %0d words: %0d fills, %0d rotates, %0d reads, %0d writes",
             op_count[srr_pkg::OP_FILL] + op_count[srr_pkg::OP_ROTATE] +
             op_count[srr_pkg::OP_READ] + op_count[srr_pkg::OP_WRITE],
             op_count[srr_pkg::OP_FILL], op_count[srr_pkg::OP_ROTATE],
             op_count[srr_pkg::OP_READ], op_count[srr_pkg::OP_WRITE]);
    $display("across %0d grid sizes, four idling mixes and %0d-cycle result hold-offs",
             sizes_used, HoldCycles);
    if (error_count == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
